FILE: rtl/sps_pkg.sv
// ----------------------------------------------------------------------------
// Strict-priority scheduler package
// Shared widths, codes, the controller state type and the command bundle.
// ----------------------------------------------------------------------------
package sps_pkg;

  // Field widths of the input and result beats.
  localparam int ACT_W  = 2;
  localparam int PRIO_W = 5;
  localparam int QIDX_W = 4;
  localparam int TID_W  = 6;
  localparam int STAT_W = 2;

  // Default sizes.
  localparam int TASK_SLOTS_DEF = 64;
  localparam int LEVELS_DEF     = 16;

  // Highest priority a create may request.
  localparam logic [PRIO_W-1:0] PRIO_MAX = PRIO_W'(16);

  // Action codes.
  localparam logic [ACT_W-1:0] ACT_CREATE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_PUSH   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_NEXT   = 2'd2;
  localparam logic [ACT_W-1:0] ACT_NOP    = 2'd3;

  // Status codes.
  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BAD_PRIO = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NONE     = 2'd3;

  // State change that an accepted beat will commit.
  typedef enum logic [1:0] {
    OP_NONE,
    OP_PUSH,
    OP_CREATE,
    OP_POP
  } op_t;

  // Controller states.
  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the input beat and read the link table
    logic commit;  // update the queues and load the result register
  } ctl_cmd_t;

endpackage

FILE: rtl/sps_if.sv
// ----------------------------------------------------------------------------
// Scheduler channel interfaces
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
interface sps_in_if;
  import sps_pkg::*;

  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [PRIO_W-1:0] priority_req;
  logic [QIDX_W-1:0] queue_index;
  logic [TID_W-1:0]  task_id;

  modport source (output valid, action, priority_req, queue_index, task_id,
                  input ready);
  modport sink   (input valid, action, priority_req, queue_index, task_id,
                  output ready);
endinterface

interface sps_out_if;
  import sps_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [TID_W-1:0]  result_task;
  logic [TID_W-1:0]  parent_task;

  modport source (output valid, status, result_task, parent_task,
                  input ready);
  modport sink   (input valid, status, result_task, parent_task,
                  output ready);
endinterface

FILE: rtl/strict_priority_task_scheduler.sv
// Result: a result beat is offered after the commit that follows the accept
//   of its request beat; the commit waits while an earlier result is still
//   waiting to be taken. A new request is taken only after that commit, which
//   follows the registered link-table read that an accept issues.
// Reset: synchronous, active low; clears the task count, active task and
//   queue occupancy. Queue pointers and the link table need no clearing.
// ----------------------------------------------------------------------------
// Strict-priority task scheduler
// Sixteen FIFO ready queues linked through a per-task next-link table, with
// create, push and next operations and one result beat per request beat.
// ----------------------------------------------------------------------------
module strict_priority_task_scheduler #(
  parameter int TASK_SLOTS = sps_pkg::TASK_SLOTS_DEF,
  parameter int LEVELS     = sps_pkg::LEVELS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  sps_in_if.sink    in_chan,
  sps_out_if.source out_chan
);
  import sps_pkg::*;

  // The controller owns the handshakes and sequencing; the datapath holds the
  // queues. A request beat is accepted in the idle state, where the beat is
  // decoded against the current queue state and the link of the head that a
  // "next" would pop is read from the link table into a register. In the
  // EXEC state that follows, once the result register is free, the captured
  // change is committed: queue heads and tails, occupancy bits, active task
  // and task count are updated and the result beat enters the output register.
  //
  // The output register lets the scheduler accept a new request beat while a
  // previous result beat is still waiting; only the commit waits for the
  // result register to drain.

  ctl_cmd_t cmd;

  sps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd)
  );

  sps_dpath #(
    .TASK_SLOTS (TASK_SLOTS),
    .LEVELS     (LEVELS)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .action       (in_chan.action),
    .priority_req (in_chan.priority_req),
    .queue_index  (in_chan.queue_index),
    .task_id      (in_chan.task_id),
    .status       (out_chan.status),
    .result_task  (out_chan.result_task),
    .parent_task  (out_chan.parent_task)
  );

  // Only one request is in flight: after an accept the input is held off.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("request accepted while another is in flight");

  // Every accepted request is followed by a pending result beat.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> ##1 out_chan.valid)
    else $error("accepted request produced no result beat");

  // A result beat only appears through a commit of a captured request.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_chan.valid) |-> $past(cmd.commit))
    else $error("result beat appeared without a commit");

  // Nothing is committed while an older result would be overwritten.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.ready) |=> $stable(out_chan.status) &&
      $stable(out_chan.result_task) && $stable(out_chan.parent_task))
    else $error("pending result beat overwritten");

endmodule

FILE: rtl/sps_ctrl.sv
// ----------------------------------------------------------------------------
// Scheduler controller
// Two-state sequencer: accept a beat, then commit it once the result
// register is free.
// ----------------------------------------------------------------------------
module sps_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output sps_pkg::ctl_cmd_t  cmd
);
  import sps_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd.load      = 1'b0;
    cmd.commit    = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        // The result register must be empty or drained at this edge.
        if (!out_valid_r || out_ready) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

FILE: rtl/sps_dpath.sv
// ----------------------------------------------------------------------------
// Scheduler datapath
// Ready-queue heads and tails, the task link table, decode and result register.
// ----------------------------------------------------------------------------
module sps_dpath #(
  parameter int TASK_SLOTS = sps_pkg::TASK_SLOTS_DEF,
  parameter int LEVELS     = sps_pkg::LEVELS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  sps_pkg::ctl_cmd_t          cmd,
  input  logic [sps_pkg::ACT_W-1:0]  action,
  input  logic [sps_pkg::PRIO_W-1:0] priority_req,
  input  logic [sps_pkg::QIDX_W-1:0] queue_index,
  input  logic [sps_pkg::TID_W-1:0]  task_id,
  output logic [sps_pkg::STAT_W-1:0] status,
  output logic [sps_pkg::TID_W-1:0]  result_task,
  output logic [sps_pkg::TID_W-1:0]  parent_task
);
  import sps_pkg::*;

  localparam int ID_W  = $clog2(TASK_SLOTS);
  localparam int CNT_W = $clog2(TASK_SLOTS + 1);
  localparam int LVL_W = $clog2(LEVELS);
  // Wide enough to hold LEVELS and TASK_SLOTS for range checks.
  localparam int QCMP_W = QIDX_W + 1;
  localparam int TCMP_W = 9;

  // Scheduler state.
  logic [CNT_W-1:0] tasks_made_r;
  logic             active_valid_r;
  logic [ID_W-1:0]  active_task_r;
  logic [LEVELS-1:0] nonempty_r;
  logic [ID_W-1:0]  head_r [LEVELS];
  logic [ID_W-1:0]  tail_r [LEVELS];
  logic [ID_W-1:0]  link_mem [TASK_SLOTS];
  logic [ID_W-1:0]  link_rd_r;

  // Captured beat.
  op_t              op_r, op_nxt;
  logic [LVL_W-1:0] q_r, q_nxt;
  logic [ID_W-1:0]  id_r, id_nxt;
  logic [STAT_W-1:0] stat_r, stat_nxt;
  logic [TID_W-1:0] res_r, res_nxt;
  logic [TID_W-1:0] par_r, par_nxt;

  // Result register.
  logic [STAT_W-1:0] out_stat_r;
  logic [TID_W-1:0]  out_res_r;
  logic [TID_W-1:0]  out_par_r;

  logic             found;
  logic [LVL_W-1:0] pe_q;
  logic [PRIO_W-1:0] prio_m1;
  logic             prio_ok;
  logic             full;
  logic             push_ok;
  logic             create_wr;
  logic             append;
  logic             mem_we;
  logic [ID_W-1:0]  mem_wa;
  logic [ID_W-1:0]  mem_wd;

  // Lowest-numbered non-empty queue.
  always_comb begin
    found = 1'b0;
    pe_q  = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (nonempty_r[i]) begin
        found = 1'b1;
        pe_q  = LVL_W'(i);
      end
    end
  end

  assign prio_m1 = priority_req - PRIO_W'(1);
  assign prio_ok = (priority_req != '0) && (priority_req <= PRIO_MAX);
  assign full    = (tasks_made_r == CNT_W'(TASK_SLOTS));
  assign push_ok = ({1'b0, queue_index} < QCMP_W'(LEVELS)) &&
                   (TCMP_W'(task_id) < TCMP_W'(TASK_SLOTS));

  // Decode the incoming beat into the change to commit and its result.
  always_comb begin
    op_nxt   = OP_NONE;
    q_nxt    = '0;
    id_nxt   = '0;
    stat_nxt = STAT_OK;
    res_nxt  = '0;
    par_nxt  = '0;
    case (action)
      ACT_CREATE: begin
        if (!prio_ok) begin
          stat_nxt = STAT_BAD_PRIO;
        end else if (full) begin
          stat_nxt = STAT_FULL;
        end else begin
          op_nxt  = OP_CREATE;
          id_nxt  = tasks_made_r[ID_W-1:0];
          // Priorities beyond the last queue saturate onto it.
          if (prio_m1 >= PRIO_W'(LEVELS)) begin
            q_nxt = LVL_W'(LEVELS - 1);
          end else begin
            q_nxt = prio_m1[LVL_W-1:0];
          end
          res_nxt = TID_W'(tasks_made_r[ID_W-1:0]);
          par_nxt = active_valid_r ? TID_W'(active_task_r) : '0;
        end
      end
      ACT_PUSH: begin
        if (push_ok) begin
          op_nxt = OP_PUSH;
          q_nxt  = queue_index[LVL_W-1:0];
          id_nxt = ID_W'(task_id);
        end
      end
      ACT_NEXT: begin
        if (!found) begin
          stat_nxt = STAT_NONE;
        end else begin
          op_nxt  = OP_POP;
          q_nxt   = pe_q;
          id_nxt  = head_r[pe_q];
          res_nxt = TID_W'(head_r[pe_q]);
        end
      end
      default: begin
        op_nxt = OP_NONE;
      end
    endcase
  end

  // A new task starts with a cleared link; appending writes the old tail's link.
  assign create_wr = cmd.load && (op_nxt == OP_CREATE);
  assign append    = (op_r == OP_PUSH || op_r == OP_CREATE) && nonempty_r[q_r];
  assign mem_we    = create_wr || (cmd.commit && append);
  assign mem_wa    = create_wr ? id_nxt : tail_r[q_r];
  assign mem_wd    = create_wr ? '0 : id_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_wa] <= mem_wd;
    end
    if (cmd.load) begin
      link_rd_r <= link_mem[head_r[pe_q]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= op_nxt;
      q_r    <= q_nxt;
      id_r   <= id_nxt;
      stat_r <= stat_nxt;
      res_r  <= res_nxt;
      par_r  <= par_nxt;
    end
    if (cmd.commit) begin
      out_stat_r <= stat_r;
      out_res_r  <= res_r;
      out_par_r  <= par_r;
    end
  end

  // Queue heads and tails have no reset; nonempty bits guard them.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      case (op_r)
        OP_PUSH, OP_CREATE: begin
          if (!nonempty_r[q_r]) begin
            head_r[q_r] <= id_r;
          end
          tail_r[q_r] <= id_r;
        end
        OP_POP: begin
          if (head_r[q_r] != tail_r[q_r]) begin
            head_r[q_r] <= link_rd_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tasks_made_r   <= '0;
      active_valid_r <= 1'b0;
      active_task_r  <= '0;
      nonempty_r     <= '0;
    end else if (cmd.commit) begin
      case (op_r)
        OP_CREATE: begin
          tasks_made_r   <= tasks_made_r + CNT_W'(1);
          nonempty_r[q_r] <= 1'b1;
        end
        OP_PUSH: begin
          nonempty_r[q_r] <= 1'b1;
        end
        OP_POP: begin
          if (head_r[q_r] == tail_r[q_r]) begin
            nonempty_r[q_r] <= 1'b0;
          end
          active_valid_r <= 1'b1;
          active_task_r  <= id_r;
        end
        default: begin
        end
      endcase
    end
  end

  assign status      = out_stat_r;
  assign result_task = out_res_r;
  assign parent_task = out_par_r;

endmodule
